// ----- design/uart_status_and_rx_fifo_defines.svh -----
// Assertion macros shared by the UART status and receive buffer block.
// Included by the top level; depends on nothing else.
`ifndef UART_STATUS_AND_RX_FIFO_DEFINES_SVH
`define UART_STATUS_AND_RX_FIFO_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define USRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define USRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/usrf_pkg.sv -----
// Shared types and constants for the UART status and receive buffer block.
// No dependencies.
package usrf_pkg;

	// Transaction commands
	localparam logic [2:0] CMD_LINE_RX   = 3'd0;
	localparam logic [2:0] CMD_RD_DATA   = 3'd1;
	localparam logic [2:0] CMD_WR_DATA   = 3'd2;
	localparam logic [2:0] CMD_WR_STATUS = 3'd3;
	localparam logic [2:0] CMD_WR_CTRL   = 3'd4;
	localparam logic [2:0] CMD_WR_SREG   = 3'd5;

	// Bit positions in status / control (shared layout) and in SREG
	localparam int unsigned BIT_RXC    = 7;
	localparam int unsigned BIT_TXC    = 6;
	localparam int unsigned BIT_UDRE   = 5;
	localparam int unsigned BIT_RXEN   = 4;
	localparam int unsigned BIT_SREG_I = 7;

	localparam logic [7:0] ERR_KEEP     = 8'hE3;
	localparam logic [7:0] STATUS_RESET = 8'h20;

	// Receive buffer fill levels
	localparam logic [1:0] FILL_EMPTY = 2'd0;
	localparam logic [1:0] FILL_ONE   = 2'd1;
	localparam logic [1:0] FILL_TWO   = 2'd2;

	typedef struct packed {
		logic [7:0] rx_data;
		logic [7:0] rx_hold;
		logic [1:0] rx_fill;
		logic [7:0] status;
		logic [7:0] control;
	} usrf_state_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] status_image;
		logic [7:0] control_image;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       irq_rx_complete;
		logic       irq_tx_complete;
		logic       irq_data_empty;
		logic       int_delay;
	} usrf_result_t;

endpackage

// ----- design/uart_status_and_rx_fifo.sv -----
// Top level of the UART register model with a two-entry receive buffer.
// Depends on usrf_pkg, usrf_step and uart_status_and_rx_fifo_defines.svh.
//
// Each accepted transaction (a line byte, a data read or write, a status,
// control or SREG write) is applied to the register state in the cycle it
// is accepted, and its one result lands in the output register on the same
// edge, visible from the next cycle. One transaction can be accepted every
// cycle unless in_stall holds it off; the single output register sets that
// rate. in_stall rises only while a result waits and out_stall is
// high, so a result being taken frees the slot for a new transaction in the
// same cycle. After reset the status register reads 0x20 (data empty), the
// control register and receive data read zero and the buffer is empty.
`include "uart_status_and_rx_fifo_defines.svh"

module uart_status_and_rx_fifo (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] cmd,
	input  logic [7:0] data_in,
	input  logic       cpu_int_enable,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic [7:0] status_image,
	output logic [7:0] control_image,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       irq_rx_complete,
	output logic       irq_tx_complete,
	output logic       irq_data_empty,
	output logic       int_delay
);

	// Register state
	logic [7:0] rx_data_q;
	logic [7:0] rx_hold_q;
	logic [1:0] rx_fill_q;
	logic [7:0] status_q;
	logic [7:0] control_q;

	usrf_pkg::usrf_state_t  cur_state;
	usrf_pkg::usrf_state_t  nxt_state;
	usrf_pkg::usrf_result_t step_res;
	usrf_pkg::usrf_result_t res_q;
	logic                   out_valid_q;
	logic                   accept;

	// Hold off new transactions only while a result waits on a stalled sink.
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign cur_state = '{
		rx_data: rx_data_q,
		rx_hold: rx_hold_q,
		rx_fill: rx_fill_q,
		status:  status_q,
		control: control_q
	};

	usrf_step u_step (
		.cur            (cur_state),
		.cmd            (cmd),
		.data_in        (data_in),
		.cpu_int_enable (cpu_int_enable),
		.nxt            (nxt_state),
		.res            (step_res)
	);

	// Advance the register state on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_data_q <= '0;
			rx_fill_q <= usrf_pkg::FILL_EMPTY;
			status_q  <= usrf_pkg::STATUS_RESET;
			control_q <= '0;
		end else if (accept) begin
			rx_data_q <= nxt_state.rx_data;
			rx_fill_q <= nxt_state.rx_fill;
			status_q  <= nxt_state.status;
			control_q <= nxt_state.control;
		end
	end

	// Hold byte is undefined until a second line byte is written.
	always_ff @(posedge clk) begin
		if (accept) begin
			rx_hold_q <= nxt_state.rx_hold;
		end
	end

	// Output register: fill on accept, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= step_res;
		end
	end

	assign out_valid       = out_valid_q;
	assign read_data       = res_q.read_data;
	assign status_image    = res_q.status_image;
	assign control_image   = res_q.control_image;
	assign tx_valid        = res_q.tx_valid;
	assign tx_byte         = res_q.tx_byte;
	assign irq_rx_complete = res_q.irq_rx_complete;
	assign irq_tx_complete = res_q.irq_tx_complete;
	assign irq_data_empty  = res_q.irq_data_empty;
	assign int_delay       = res_q.int_delay;

	// RXC tracks a non-empty receive buffer.
	`USRF_ASSERT_NOW(a_rxc_matches_fill, clk, arst_n, 1'b1,
		status_q[usrf_pkg::BIT_RXC] == (rx_fill_q != usrf_pkg::FILL_EMPTY),
		"RXC out of step with receive fill count")

	// The fill count never passes two entries.
	`USRF_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1,
		rx_fill_q != 2'd3, "receive fill count out of range")

	// An accepted data write shows up as a transmit in the next result.
	`USRF_ASSERT_NEXT(a_wr_data_tx, clk, arst_n,
		accept && (cmd == usrf_pkg::CMD_WR_DATA),
		out_valid && tx_valid && (tx_byte == $past(data_in)),
		"data write did not produce a transmit")

	// At most one interrupt request per result; a data write may raise
	// transmit complete and data empty together.
	`USRF_ASSERT_NOW(a_one_irq, clk, arst_n, out_valid && !tx_valid,
		$onehot0({irq_rx_complete, irq_tx_complete, irq_data_empty}),
		"more than one interrupt raised by one transaction")

endmodule

// ----- design/usrf_step.sv -----
// Next-state and result logic for one transaction of the UART register model.
// Depends on usrf_pkg.
module usrf_step (
	input  usrf_pkg::usrf_state_t  cur,
	input  logic [2:0]             cmd,
	input  logic [7:0]             data_in,
	input  logic                   cpu_int_enable,
	output usrf_pkg::usrf_state_t  nxt,
	output usrf_pkg::usrf_result_t res
);

	always_comb begin
		nxt = cur;
		res = '0;
		unique case (cmd)
			usrf_pkg::CMD_LINE_RX: begin
				if (cur.control[usrf_pkg::BIT_RXEN]) begin
					if (cur.rx_fill == usrf_pkg::FILL_EMPTY) begin
						nxt.rx_data = data_in;
						nxt.rx_fill = usrf_pkg::FILL_ONE;
						nxt.status[usrf_pkg::BIT_RXC] = 1'b1;
						res.irq_rx_complete = cur.control[usrf_pkg::BIT_RXC] & cpu_int_enable;
					end else if (cur.rx_fill == usrf_pkg::FILL_ONE) begin
						nxt.rx_hold = data_in;
						nxt.rx_fill = usrf_pkg::FILL_TWO;
					end
				end
			end
			usrf_pkg::CMD_RD_DATA: begin
				res.read_data = cur.rx_data;
				if (cur.rx_fill != usrf_pkg::FILL_EMPTY) begin
					if (cur.rx_fill[1]) begin
						// advance the hold byte, keep RXC
						nxt.rx_data = cur.rx_hold;
						nxt.status  = cur.status & usrf_pkg::ERR_KEEP;
						nxt.rx_fill = usrf_pkg::FILL_ONE;
						res.irq_rx_complete = cur.control[usrf_pkg::BIT_RXC] & cpu_int_enable;
					end else begin
						nxt.status[usrf_pkg::BIT_RXC] = 1'b0;
						nxt.rx_fill = usrf_pkg::FILL_EMPTY;
					end
				end
			end
			usrf_pkg::CMD_WR_DATA: begin
				res.tx_valid = 1'b1;
				res.tx_byte  = data_in;
				if (cur.control[usrf_pkg::BIT_TXC] && cpu_int_enable) begin
					res.irq_tx_complete = 1'b1;
				end else begin
					nxt.status[usrf_pkg::BIT_TXC] = 1'b1;
				end
				res.irq_data_empty = cur.control[usrf_pkg::BIT_UDRE] & cpu_int_enable;
			end
			usrf_pkg::CMD_WR_STATUS: begin
				if (data_in[usrf_pkg::BIT_TXC]) begin
					nxt.status[usrf_pkg::BIT_TXC] = 1'b0;
				end
			end
			usrf_pkg::CMD_WR_CTRL: begin
				// flush first, then check rising enables against the flushed flags
				if (!data_in[usrf_pkg::BIT_RXEN]) begin
					nxt.rx_fill = usrf_pkg::FILL_EMPTY;
					nxt.status[usrf_pkg::BIT_RXC] = 1'b0;
				end
				if (data_in[usrf_pkg::BIT_RXC] && !cur.control[usrf_pkg::BIT_RXC]
						&& nxt.status[usrf_pkg::BIT_RXC]) begin
					res.irq_rx_complete = cpu_int_enable;
				end else if (data_in[usrf_pkg::BIT_TXC] && !cur.control[usrf_pkg::BIT_TXC]
						&& nxt.status[usrf_pkg::BIT_TXC]) begin
					if (cpu_int_enable) begin
						res.irq_tx_complete = 1'b1;
						nxt.status[usrf_pkg::BIT_TXC] = 1'b0;
					end
				end else if (data_in[usrf_pkg::BIT_UDRE] && !cur.control[usrf_pkg::BIT_UDRE]
						&& nxt.status[usrf_pkg::BIT_UDRE]) begin
					res.irq_data_empty = cpu_int_enable;
				end
				nxt.control = data_in;
			end
			usrf_pkg::CMD_WR_SREG: begin
				if (data_in[usrf_pkg::BIT_SREG_I] && !cpu_int_enable) begin
					res.int_delay = 1'b1;
					if (cur.control[usrf_pkg::BIT_RXC] && cur.status[usrf_pkg::BIT_RXC]) begin
						res.irq_rx_complete = 1'b1;
					end else if (cur.control[usrf_pkg::BIT_TXC]
							&& cur.status[usrf_pkg::BIT_TXC]) begin
						res.irq_tx_complete = 1'b1;
						nxt.status[usrf_pkg::BIT_TXC] = 1'b0;
					end else if (cur.control[usrf_pkg::BIT_UDRE]
							&& cur.status[usrf_pkg::BIT_UDRE]) begin
						res.irq_data_empty = 1'b1;
					end
				end
			end
			default: begin
				// unused commands only report the images
			end
		endcase
		res.status_image  = nxt.status;
		res.control_image = nxt.control;
	end

endmodule

// ----- bench/usrf_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the UART status and receive buffer block: mirrors the register
// state, predicts one result per accepted transaction and compares it field by
// field. Depends on usrf_pkg.

module usrf_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [7:0]  data_in,
	input  logic        cpu_int_enable,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  read_data,
	input  logic [7:0]  status_image,
	input  logic [7:0]  control_image,
	input  logic        tx_valid,
	input  logic [7:0]  tx_byte,
	input  logic        irq_rx_complete,
	input  logic        irq_tx_complete,
	input  logic        irq_data_empty,
	input  logic        int_delay,
	output int unsigned fail_count,
	output int unsigned pending_count
);

	localparam int unsigned MAX_REPORTS = 40;

	logic [7:0]             mirror_rx_data;
	logic [7:0]             mirror_rx_hold;
	logic [1:0]             mirror_fill;
	logic [7:0]             mirror_status;
	logic [7:0]             mirror_control;
	usrf_pkg::usrf_result_t due_results[$];

	task automatic report_mismatch(input string msg);
		if (fail_count < MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%02h, want 0x%02h", name, got, want));
	endtask

	task automatic check_bit(input string name, input logic got, input logic want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0b, want %0b", name, got, want));
	endtask

	// Apply one register access to the mirrored state and build its result.
	task automatic apply_uart_access(input logic [2:0] c, input logic [7:0] d,
			input logic ie, output usrf_pkg::usrf_result_t r);
		r = '0;
		case (c)
		usrf_pkg::CMD_LINE_RX: begin
			if (mirror_control[usrf_pkg::BIT_RXEN]) begin
				if (mirror_fill == usrf_pkg::FILL_EMPTY) begin
					mirror_rx_data = d;
					mirror_fill = usrf_pkg::FILL_ONE;
					mirror_status[usrf_pkg::BIT_RXC] = 1'b1;
					r.irq_rx_complete = mirror_control[usrf_pkg::BIT_RXC] & ie;
				end else if (mirror_fill == usrf_pkg::FILL_ONE) begin
					mirror_rx_hold = d;
					mirror_fill = usrf_pkg::FILL_TWO;
				end
			end
		end
		usrf_pkg::CMD_RD_DATA: begin
			r.read_data = mirror_rx_data;
			if (mirror_fill == usrf_pkg::FILL_TWO) begin
				mirror_rx_data = mirror_rx_hold;
				mirror_status = mirror_status & usrf_pkg::ERR_KEEP;
				r.irq_rx_complete = mirror_control[usrf_pkg::BIT_RXC] & ie;
				mirror_fill = usrf_pkg::FILL_ONE;
			end else if (mirror_fill == usrf_pkg::FILL_ONE) begin
				mirror_status[usrf_pkg::BIT_RXC] = 1'b0;
				mirror_fill = usrf_pkg::FILL_EMPTY;
			end
		end
		usrf_pkg::CMD_WR_DATA: begin
			r.tx_valid = 1'b1;
			r.tx_byte = d;
			if (mirror_control[usrf_pkg::BIT_TXC] && ie)
				r.irq_tx_complete = 1'b1;
			else
				mirror_status[usrf_pkg::BIT_TXC] = 1'b1;
			r.irq_data_empty = mirror_control[usrf_pkg::BIT_UDRE] & ie;
		end
		usrf_pkg::CMD_WR_STATUS: begin
			if (d[usrf_pkg::BIT_TXC])
				mirror_status[usrf_pkg::BIT_TXC] = 1'b0;
		end
		usrf_pkg::CMD_WR_CTRL: begin
			if (!d[usrf_pkg::BIT_RXEN]) begin
				mirror_fill = usrf_pkg::FILL_EMPTY;
				mirror_status[usrf_pkg::BIT_RXC] = 1'b0;
			end
			// only the first rising enable with its flag set counts
			if (d[usrf_pkg::BIT_RXC] && !mirror_control[usrf_pkg::BIT_RXC]
					&& mirror_status[usrf_pkg::BIT_RXC]) begin
				r.irq_rx_complete = ie;
			end else if (d[usrf_pkg::BIT_TXC] && !mirror_control[usrf_pkg::BIT_TXC]
					&& mirror_status[usrf_pkg::BIT_TXC]) begin
				if (ie) begin
					r.irq_tx_complete = 1'b1;
					mirror_status[usrf_pkg::BIT_TXC] = 1'b0;
				end
			end else if (d[usrf_pkg::BIT_UDRE] && !mirror_control[usrf_pkg::BIT_UDRE]
					&& mirror_status[usrf_pkg::BIT_UDRE]) begin
				r.irq_data_empty = ie;
			end
			mirror_control = d;
		end
		usrf_pkg::CMD_WR_SREG: begin
			if (d[usrf_pkg::BIT_SREG_I] && !ie) begin
				r.int_delay = 1'b1;
				if (mirror_control[usrf_pkg::BIT_RXC]
						&& mirror_status[usrf_pkg::BIT_RXC]) begin
					r.irq_rx_complete = 1'b1;
				end else if (mirror_control[usrf_pkg::BIT_TXC]
						&& mirror_status[usrf_pkg::BIT_TXC]) begin
					r.irq_tx_complete = 1'b1;
					mirror_status[usrf_pkg::BIT_TXC] = 1'b0;
				end else if (mirror_control[usrf_pkg::BIT_UDRE]
						&& mirror_status[usrf_pkg::BIT_UDRE]) begin
					r.irq_data_empty = 1'b1;
				end
			end
		end
		default: ;
		endcase
		r.status_image = mirror_status;
		r.control_image = mirror_control;
	endtask

	always @(posedge clk or negedge arst_n) begin
		usrf_pkg::usrf_result_t predicted;
		usrf_pkg::usrf_result_t oldest;
		if (!arst_n) begin
			mirror_rx_data = '0;
			mirror_rx_hold = '0;
			mirror_fill = usrf_pkg::FILL_EMPTY;
			mirror_status = usrf_pkg::STATUS_RESET;
			mirror_control = '0;
			due_results.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			// a result leaves only after its transaction is registered: retire first
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					report_mismatch("result with no transaction outstanding");
				end else begin
					oldest = due_results.pop_front();
					check_field("read_data", read_data, oldest.read_data);
					check_field("status_image", status_image, oldest.status_image);
					check_field("control_image", control_image, oldest.control_image);
					check_bit("tx_valid", tx_valid, oldest.tx_valid);
					check_field("tx_byte", tx_byte, oldest.tx_byte);
					check_bit("irq_rx_complete", irq_rx_complete, oldest.irq_rx_complete);
					check_bit("irq_tx_complete", irq_tx_complete, oldest.irq_tx_complete);
					check_bit("irq_data_empty", irq_data_empty, oldest.irq_data_empty);
					check_bit("int_delay", int_delay, oldest.int_delay);
				end
			end
			if (in_valid && !in_stall) begin
				apply_uart_access(cmd, data_in, cpu_int_enable, predicted);
				due_results.push_back(predicted);
			end
			pending_count = due_results.size();
		end
	end

endmodule

// ----- bench/tb_uart_status_and_rx_fifo.sv -----
`timescale 1ns / 100ps
// Top of the testbench for uart_status_and_rx_fifo: drives register accesses
// and receiver stalls, and gives the verdict from usrf_checker's count.
// Depends on usrf_pkg, the block and usrf_checker.

module tb_uart_status_and_rx_fifo;

	localparam int unsigned HALF_PERIOD     = 5;
	localparam int unsigned RESET_CYCLES    = 8;
	localparam int unsigned TOTAL_ACCESSES  = 1400;
	localparam int unsigned CALM_TAIL       = 200;     // final stretch with no idling
	localparam int unsigned HOLD_OFF_CYCLES = 40;
	localparam int unsigned HOLD_OFF_AT     = 400;
	localparam int unsigned DRAIN_EVERY     = 300;
	localparam int unsigned DRAIN_CYCLES    = 4;
	localparam int unsigned CYCLE_LIMIT     = 100000;

	// Command codes the block treats as no-ops
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  cmd;
	logic [7:0]  data_in;
	logic        cpu_int_enable;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  read_data;
	logic [7:0]  status_image;
	logic [7:0]  control_image;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        irq_rx_complete;
	logic        irq_tx_complete;
	logic        irq_data_empty;
	logic        int_delay;

	int unsigned fail_count;
	int unsigned pending_count;
	int unsigned access_count;
	int unsigned cycle_count;
	bit          idle_enable;
	bit          hold_off_req;

	uart_status_and_rx_fifo DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cmd             (cmd),
		.data_in         (data_in),
		.cpu_int_enable  (cpu_int_enable),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.read_data       (read_data),
		.status_image    (status_image),
		.control_image   (control_image),
		.tx_valid        (tx_valid),
		.tx_byte         (tx_byte),
		.irq_rx_complete (irq_rx_complete),
		.irq_tx_complete (irq_tx_complete),
		.irq_data_empty  (irq_data_empty),
		.int_delay       (int_delay)
	);

	usrf_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cmd             (cmd),
		.data_in         (data_in),
		.cpu_int_enable  (cpu_int_enable),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.read_data       (read_data),
		.status_image    (status_image),
		.control_image   (control_image),
		.tx_valid        (tx_valid),
		.tx_byte         (tx_byte),
		.irq_rx_complete (irq_rx_complete),
		.irq_tx_complete (irq_tx_complete),
		.irq_data_empty  (irq_data_empty),
		.int_delay       (int_delay),
		.fail_count      (fail_count),
		.pending_count   (pending_count)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// Count cycles; the watchdog below ends a hung run.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// Receiver: stall in random bursts while idling is on.
	// A hold-off request keeps the output stalled for a long stretch so the
	// result register fills and the block pushes back on the sender.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			end else if (idle_enable && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one transaction at the falling edge, optionally after an idle gap,
	// and hold it until the block accepts it at a rising edge.
	task automatic send_access(input logic [2:0] c, input logic [7:0] d, input logic ie);
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= c;
		data_in <= d;
		cpu_int_enable <= ie;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (c <= usrf_pkg::CMD_WR_SREG)
			access_count++;
	endtask

	// Drop valid and hold until every predicted result has come back.
	task automatic wait_for_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
	endtask

	// One random access. Inside a receive episode keep RXEN set on control
	// writes and skip the spare commands so the buffer logic gets exercised.
	task automatic send_random_access(input bit in_episode);
		int unsigned pick;
		logic [2:0]  c;
		logic [7:0]  d;
		pick = $urandom_range(0, 99);
		d = 8'($urandom_range(0, 255));
		if (pick < 30) begin
			c = usrf_pkg::CMD_LINE_RX;
		end else if (pick < 55) begin
			c = usrf_pkg::CMD_RD_DATA;
		end else if (pick < 67) begin
			c = usrf_pkg::CMD_WR_DATA;
		end else if (pick < 75) begin
			c = usrf_pkg::CMD_WR_STATUS;
		end else if (pick < 87) begin
			c = usrf_pkg::CMD_WR_CTRL;
			if (in_episode)
				d[usrf_pkg::BIT_RXEN] = 1'b1;
		end else if (pick < 97 || in_episode) begin
			c = usrf_pkg::CMD_WR_SREG;
		end else begin
			c = ($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
		end
		send_access(c, d, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		logic [7:0]  ctrl_byte;
		int unsigned next_drain;
		bit          hold_off_done;

		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = usrf_pkg::CMD_LINE_RX;
		data_in = '0;
		cpu_int_enable = 1'b0;
		idle_enable = 1'b1;
		hold_off_req = 1'b0;
		access_count = 0;
		next_drain = DRAIN_EVERY;
		hold_off_done = 1'b0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Directed opening: empty read, dropped byte with RXEN off, then
		// enables rising, buffer filling to two, overflow drop and draining.
		send_access(usrf_pkg::CMD_RD_DATA,   8'h00, 1'b1);   // read with empty buffer
		send_access(usrf_pkg::CMD_LINE_RX,   8'hFF, 1'b1);   // receiver off: drop
		send_access(usrf_pkg::CMD_WR_CTRL,   8'hF0, 1'b1);   // all enables up, UDRE request
		send_access(usrf_pkg::CMD_LINE_RX,   8'h00, 1'b1);   // first byte, RXC request
		send_access(usrf_pkg::CMD_LINE_RX,   8'hFF, 1'b1);   // into hold byte
		send_access(usrf_pkg::CMD_LINE_RX,   8'hA5, 1'b1);   // buffer full: drop
		send_access(usrf_pkg::CMD_RD_DATA,   8'h00, 1'b1);   // hold byte moves up
		send_access(usrf_pkg::CMD_RD_DATA,   8'h00, 1'b0);   // last byte, RXC clears
		send_access(usrf_pkg::CMD_RD_DATA,   8'hFF, 1'b1);   // empty again
		send_access(usrf_pkg::CMD_WR_DATA,   8'h5A, 1'b1);   // TXC request taken
		send_access(usrf_pkg::CMD_WR_DATA,   8'hA5, 1'b0);   // not taken: TXC set
		send_access(usrf_pkg::CMD_WR_STATUS, 8'h40, 1'b1);   // write one to clear TXC
		send_access(usrf_pkg::CMD_WR_DATA,   8'hFF, 1'b0);   // TXC set again
		send_access(usrf_pkg::CMD_WR_CTRL,   8'h00, 1'b1);   // everything off, flush
		send_access(usrf_pkg::CMD_WR_CTRL,   8'h50, 1'b1);   // TXCIE rises with TXC set
		send_access(usrf_pkg::CMD_WR_SREG,   8'h80, 1'b0);   // I rises, nothing flagged
		send_access(usrf_pkg::CMD_WR_CTRL,   8'hB0, 1'b0);   // UDRIE rises, not taken
		send_access(usrf_pkg::CMD_LINE_RX,   8'h3C, 1'b0);   // RXC set, request not taken
		send_access(usrf_pkg::CMD_WR_SREG,   8'h80, 1'b0);   // I rises: RXC request first
		send_access(usrf_pkg::CMD_WR_SREG,   8'h80, 1'b1);   // I already set: no effect
		send_access(usrf_pkg::CMD_WR_SREG,   8'h7F, 1'b0);   // I bit clear: no effect
		send_access(CMD_SPARE_LO,  8'hFF, 1'b1);
		send_access(CMD_SPARE_HI,  8'h00, 1'b0);
		send_access(usrf_pkg::CMD_WR_CTRL,   8'h0F, 1'b1);   // RXEN off with a byte held
		wait_for_drain();

		// Random part: mostly receive episodes that start with a control
		// write keeping RXEN on, the rest unconstrained noise.
		while (access_count < TOTAL_ACCESSES) begin
			if ($urandom_range(0, 3) != 0) begin
				ctrl_byte = 8'($urandom_range(0, 255));
				ctrl_byte[usrf_pkg::BIT_RXEN] = 1'b1;
				send_access(usrf_pkg::CMD_WR_CTRL, ctrl_byte, 1'($urandom_range(0, 1)));
				repeat ($urandom_range(4, 12)) send_random_access(1'b1);
			end else begin
				repeat ($urandom_range(1, 6)) send_random_access(1'b0);
			end
			if (!hold_off_done && access_count >= HOLD_OFF_AT) begin
				hold_off_done = 1'b1;
				hold_off_req = 1'b1;
			end
			if (access_count >= next_drain) begin
				next_drain += DRAIN_EVERY;
				wait_for_drain();
			end
			if (access_count + CALM_TAIL >= TOTAL_ACCESSES)
				idle_enable = 1'b0;
		end

		// Drain, let the result register settle, then decide.
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
